>>> hdl/gpt_pkg.sv
// ----------------------------------------------------------------------------
// gpt_pkg
// shared widths, parameter defaults and the result word type of the
// gshare predictor with target field
// ----------------------------------------------------------------------------
package gpt_pkg;

  // fixed width of the multi-bit channel fields
  localparam int WORD_W = 32;

  // parameter defaults for the top level
  localparam int INDEX_BITS_DEF   = 12;
  localparam int HISTORY_BITS_DEF = 12;
  localparam int COUNTER_BITS_DEF = 2;
  localparam int ADDR_BITS_DEF    = 32;

  // depth of the result queue in front of the output channel
  localparam int FIFO_DEPTH = 3;

  typedef struct packed {
    logic              pred_taken;
    logic              pred_valid;
    logic [WORD_W-1:0] pred_target;
  } pred_word_t;

endpackage

>>> hdl/gpt_if.sv
// ----------------------------------------------------------------------------
// gpt channel interfaces
// valid/ready channels for resolved branches and for predictions
// ----------------------------------------------------------------------------
interface gpt_branch_if;
  logic                      valid;
  logic                      ready;
  logic [gpt_pkg::WORD_W-1:0] pc;
  logic                      taken;
  logic [gpt_pkg::WORD_W-1:0] actual_target;

  modport source (output valid, output pc, output taken, output actual_target,
                  input ready);
  modport sink   (input valid, input pc, input taken, input actual_target,
                  output ready);
endinterface

interface gpt_pred_if;
  logic                      valid;
  logic                      ready;
  logic                      pred_taken;
  logic                      pred_valid;
  logic [gpt_pkg::WORD_W-1:0] pred_target;

  modport source (output valid, output pred_taken, output pred_valid,
                  output pred_target, input ready);
  modport sink   (input valid, input pred_taken, input pred_valid,
                  input pred_target, output ready);
endinterface

>>> hdl/gshare_predictor_with_target.sv
// ----------------------------------------------------------------------------
// gshare_predictor_with_target
// gshare direction predictor with a target field and valid flag per entry
// ----------------------------------------------------------------------------
//
//  channel | dir | word                               | handshake
//  --------+-----+------------------------------------+------------------
//  br      | in  | pc, taken, actual_target           | valid & ready
//  pred    | out | pred_taken, pred_valid, pred_target| valid & ready
//
// one word per cycle sustained while pred is ready and no sweep runs;
// each branch word goes through table read, then compute and write
// the table is one read port and one write port per cycle, bypassed for
// back-to-back words that hit the same entry
// after rst the table is swept once over all 2**INDEX_BITS entries (4096
// at the defaults), one entry a cycle, with br.ready low
// results go into a 3-word queue; br.ready drops when words in flight plus
// queued words reach three, so a stalled pred side holds without loss
//
module gshare_predictor_with_target #(
  parameter int INDEX_BITS   = gpt_pkg::INDEX_BITS_DEF,
  parameter int HISTORY_BITS = gpt_pkg::HISTORY_BITS_DEF,
  parameter int COUNTER_BITS = gpt_pkg::COUNTER_BITS_DEF,
  parameter int ADDR_BITS    = gpt_pkg::ADDR_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  gpt_branch_if.sink      br,
  gpt_pred_if.source      pred
);

  localparam int Depth  = 2 ** INDEX_BITS;
  localparam int QDepth = gpt_pkg::FIFO_DEPTH;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);
  localparam int OccW   = QCntW + 1;

  // counter levels
  localparam logic [COUNTER_BITS-1:0] CntMax    = '1;
  localparam logic [COUNTER_BITS-1:0] CntZero   = '0;
  localparam logic [COUNTER_BITS-1:0] CntWeakNt =
    COUNTER_BITS'((2 ** COUNTER_BITS) / 2 - 1);
  localparam logic [COUNTER_BITS-1:0] CntWeakT  =
    COUNTER_BITS'((2 ** COUNTER_BITS) / 2);

  // table storage
  logic [COUNTER_BITS-1:0] cnt_mem [Depth];
  logic                    vld_mem [Depth];
  logic [ADDR_BITS-1:0]    tgt_mem [Depth];

  // reset sweep
  logic                  clearing;
  logic [INDEX_BITS-1:0] clr_addr;

  // global history
  logic [HISTORY_BITS-1:0] hist;
  logic [HISTORY_BITS-1:0] hist_next;

  // input side
  logic                  accept;
  logic [ADDR_BITS-1:0]  pc_a;
  logic [ADDR_BITS-1:0]  tgt_a;
  logic [INDEX_BITS-1:0] idx;

  // read stage: word waiting on registered table data
  logic                    s1_valid;
  logic [INDEX_BITS-1:0]   s1_idx;
  logic                    s1_taken;
  logic [ADDR_BITS-1:0]    s1_tgt;
  logic [COUNTER_BITS-1:0] rd_cnt;
  logic                    rd_vld;
  logic [ADDR_BITS-1:0]    rd_tgt;

  // bypass of the entry written last cycle
  logic                    fw_valid;
  logic [INDEX_BITS-1:0]   fw_idx;
  logic [COUNTER_BITS-1:0] fw_cnt;
  logic                    fw_vld;
  logic [ADDR_BITS-1:0]    fw_tgt;

  // current entry and its update
  logic                    fw_hit;
  logic [COUNTER_BITS-1:0] cur_cnt;
  logic                    cur_vld;
  logic [ADDR_BITS-1:0]    cur_tgt;
  logic [COUNTER_BITS-1:0] new_cnt;
  logic                    new_vld;
  logic [ADDR_BITS-1:0]    new_tgt;
  logic                    tgt_we;
  gpt_pkg::pred_word_t     res;

  // table write port
  logic                    tbl_we;
  logic [INDEX_BITS-1:0]   tbl_waddr;
  logic [COUNTER_BITS-1:0] tbl_wcnt;
  logic                    tbl_wvld;

  // result queue
  gpt_pkg::pred_word_t q_mem [QDepth];
  logic [QPtrW-1:0]    q_wr;
  logic [QPtrW-1:0]    q_rd;
  logic [QCntW-1:0]    q_cnt;
  logic [QCntW-1:0]    q_cnt_next;
  logic                q_pop;
  logic [OccW-1:0]     occ;

  // --------------------------------------------------------------------------
  // input side: index from pc xor history, reduced to ADDR_BITS first
  // --------------------------------------------------------------------------
  assign pc_a      = ADDR_BITS'(br.pc);
  assign tgt_a     = ADDR_BITS'(br.actual_target);
  assign idx       = INDEX_BITS'(pc_a) ^ INDEX_BITS'(hist);
  assign hist_next = HISTORY_BITS'({hist, br.taken});

  // words in flight plus queued words must leave room for one more
  assign occ      = OccW'(q_cnt) + OccW'(s1_valid);
  assign br.ready = !clearing && (occ < OccW'(QDepth));
  assign accept   = br.valid && br.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hist     <= '0;
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        hist <= hist_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_idx   <= idx;
      s1_taken <= br.taken;
      s1_tgt   <= tgt_a;
    end
  end

  // --------------------------------------------------------------------------
  // reset sweep: counters to weakly not taken, valid flags to zero
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == '1) begin
        clearing <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // compute stage: pick table data or the bypassed entry, predict, train
  // --------------------------------------------------------------------------
  assign fw_hit  = fw_valid && (fw_idx == s1_idx);
  assign cur_cnt = fw_hit ? fw_cnt : rd_cnt;
  assign cur_vld = fw_hit ? fw_vld : rd_vld;
  assign cur_tgt = fw_hit ? fw_tgt : rd_tgt;

  always_comb begin
    // saturating train
    if (s1_taken) begin
      new_cnt = (cur_cnt != CntMax) ? cur_cnt + 1'b1 : cur_cnt;
    end else begin
      new_cnt = (cur_cnt != CntZero) ? cur_cnt - 1'b1 : cur_cnt;
    end
    new_vld = cur_vld;
    new_tgt = cur_tgt;
    tgt_we  = 1'b0;
    if (cur_vld) begin
      // stale target drops the entry, counter still trained
      if (s1_tgt != cur_tgt) begin
        new_vld = 1'b0;
      end
    end else if (s1_taken) begin
      // first taken hit on an empty entry allocates it
      new_vld = 1'b1;
      new_cnt = CntWeakT;
      new_tgt = s1_tgt;
      tgt_we  = s1_valid;
    end
  end

  always_comb begin
    res.pred_taken  = cur_cnt > CntWeakNt;
    res.pred_valid  = cur_vld;
    res.pred_target = cur_vld ? gpt_pkg::WORD_W'(cur_tgt) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fw_valid <= 1'b0;
    end else begin
      fw_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      fw_idx <= s1_idx;
      fw_cnt <= new_cnt;
      fw_vld <= new_vld;
      fw_tgt <= new_tgt;
    end
  end

  // --------------------------------------------------------------------------
  // table: one write and one registered read per cycle
  // --------------------------------------------------------------------------
  assign tbl_we    = clearing || s1_valid;
  assign tbl_waddr = clearing ? clr_addr : s1_idx;
  assign tbl_wcnt  = clearing ? CntWeakNt : new_cnt;
  assign tbl_wvld  = clearing ? 1'b0 : new_vld;

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      cnt_mem[tbl_waddr] <= tbl_wcnt;
      vld_mem[tbl_waddr] <= tbl_wvld;
    end
    if (accept) begin
      rd_cnt <= cnt_mem[idx];
      rd_vld <= vld_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (tgt_we) begin
      tgt_mem[s1_idx] <= s1_tgt;
    end
    if (accept) begin
      rd_tgt <= tgt_mem[idx];
    end
  end

  // --------------------------------------------------------------------------
  // result queue toward pred
  // --------------------------------------------------------------------------
  assign q_pop = pred.valid && pred.ready;

  always_comb begin
    q_cnt_next = q_cnt;
    if (s1_valid && !q_pop) begin
      q_cnt_next = q_cnt + 1'b1;
    end else if (!s1_valid && q_pop) begin
      q_cnt_next = q_cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wr  <= '0;
      q_rd  <= '0;
      q_cnt <= '0;
    end else begin
      q_cnt <= q_cnt_next;
      if (s1_valid) begin
        q_wr <= (q_wr == QPtrW'(QDepth - 1)) ? '0 : q_wr + 1'b1;
      end
      if (q_pop) begin
        q_rd <= (q_rd == QPtrW'(QDepth - 1)) ? '0 : q_rd + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      q_mem[q_wr] <= res;
    end
  end

  assign pred.valid       = q_cnt != '0;
  assign pred.pred_taken  = q_mem[q_rd].pred_taken;
  assign pred.pred_valid  = q_mem[q_rd].pred_valid;
  assign pred.pred_target = q_mem[q_rd].pred_target;

endmodule
